// ===== src/multiset_mex_tracker_defines.svh =====
// multiset_mex_tracker_defines.svh: assertion macros for the mex tracker checker
// depends on clk and rst being visible in the scope that uses the macros
`ifndef MULTISET_MEX_TRACKER_DEFINES_SVH
`define MULTISET_MEX_TRACKER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MMT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mmt check failed");

// next-cycle implication, disabled during reset
`define MMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mmt check failed");

`endif

// ===== src/mmt_pkg.sv =====
// mmt_pkg: shared types and constants for the multiset mex tracker
// used by mmt_ctrl, mmt_datapath and the top level; depends on nothing
package mmt_pkg;

  // fixed field widths of the item and result ports, the counts and the bitmap rows
  localparam int POS_W   = 10;
  localparam int VAL_W   = 30;
  localparam int MEX_W   = 11;
  localparam int CNT_W   = 11;
  localparam int ROW_LG  = 5;
  localparam int ROW_W   = 32;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [VAL_W-1:0]  val_in_t;
  typedef logic [MEX_W-1:0]  mex_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [ROW_LG-1:0] bit_idx_t;

  localparam count_t CNT_MAX = '1;

  // item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic clr_step;
    logic stored_rd;
    logic stored_wr;
    logic sel_new;
    logic dec;
    logic cnt_rd;
    logic cnt_wr;
    logic sum_wr;
    logic scan_rd;
    logic scan_next;
    logic row_rd;
    logic finish_full;
    logic finish_row;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic is_update;
    logic pos_ok;
    logic old_in_range;
    logic new_in_range;
    logic sum_has_zero;
    logic zero_beyond;
    logic scan_last;
  } dp_status_t;

endpackage

// ===== src/multiset_mex_tracker.sv =====
// An update item gives done after a count read-modify-write on two values (old and new) and
// a scan of k row-full summary words (k from 1 to ceil(ceil((POSITIONS+1)/32)/32)).
// A load item keeps busy high while it is handled and gives no result. One item at a time.
// Reset: a clearing pass over counts and bitmap runs with busy high.
// done pulses for one cycle with mex valid; the receiver cannot stall.
module multiset_mex_tracker #(
  parameter int POSITIONS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              kind,
  input  mmt_pkg::pos_t     position,
  input  mmt_pkg::val_in_t  new_value,
  output logic              busy,
  output logic              done,
  output mmt_pkg::mex_t     mex
);

  mmt_pkg::dp_cmd_t    cmd;
  mmt_pkg::dp_status_t status;

  // sequencer
  mmt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // storage and search
  mmt_datapath #(
    .POSITIONS (POSITIONS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .kind      (kind),
    .position  (position),
    .new_value (new_value),
    .status    (status),
    .done      (done),
    .mex       (mex)
  );

endmodule

// ===== src/mmt_ctrl.sv =====
// mmt_ctrl: sequencing state machine for the multiset mex tracker
// depends on mmt_pkg for the command and status structs
module mmt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mmt_pkg::dp_status_t status,
  output logic                busy,
  output mmt_pkg::dp_cmd_t    cmd
);

  typedef enum logic [11:0] {
    ST_CLEAR    = 12'b0000_0000_0001,
    ST_IDLE     = 12'b0000_0000_0010,
    ST_FETCH    = 12'b0000_0000_0100,
    ST_DEC_RD   = 12'b0000_0000_1000,
    ST_DEC_WR   = 12'b0000_0001_0000,
    ST_DEC_SUM  = 12'b0000_0010_0000,
    ST_INC_RD   = 12'b0000_0100_0000,
    ST_INC_WR   = 12'b0000_1000_0000,
    ST_INC_SUM  = 12'b0001_0000_0000,
    ST_SCAN_RD  = 12'b0010_0000_0000,
    ST_SCAN_CHK = 12'b0100_0000_0000,
    ST_ROW_CHK  = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        priority if (status.pos_ok && status.is_update) begin
          cmd.stored_rd = 1'b1;
          state_next    = ST_DEC_RD;
        end else if (status.pos_ok) begin
          cmd.stored_wr = 1'b1;
          state_next    = ST_INC_RD;
        end else if (status.is_update) begin
          state_next = ST_SCAN_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      // remove the old value
      ST_DEC_RD: begin
        cmd.stored_wr = 1'b1;
        if (status.old_in_range) begin
          cmd.cnt_rd = 1'b1;
          state_next = ST_DEC_WR;
        end else begin
          state_next = ST_INC_RD;
        end
      end
      ST_DEC_WR: begin
        cmd.dec    = 1'b1;
        cmd.cnt_wr = 1'b1;
        state_next = ST_DEC_SUM;
      end
      ST_DEC_SUM: begin
        cmd.sum_wr = 1'b1;
        state_next = ST_INC_RD;
      end
      // add the new value
      ST_INC_RD: begin
        cmd.sel_new = 1'b1;
        priority if (status.new_in_range) begin
          cmd.cnt_rd = 1'b1;
          state_next = ST_INC_WR;
        end else if (status.is_update) begin
          state_next = ST_SCAN_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_INC_WR: begin
        cmd.sel_new = 1'b1;
        cmd.cnt_wr  = 1'b1;
        state_next  = ST_INC_SUM;
      end
      ST_INC_SUM: begin
        cmd.sel_new = 1'b1;
        cmd.sum_wr  = 1'b1;
        state_next  = status.is_update ? ST_SCAN_RD : ST_IDLE;
      end
      // search summary words for a row that is not full
      ST_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        priority if (status.sum_has_zero && status.zero_beyond) begin
          cmd.finish_full = 1'b1;
          state_next      = ST_IDLE;
        end else if (status.sum_has_zero) begin
          cmd.row_rd = 1'b1;
          state_next = ST_ROW_CHK;
        end else if (status.scan_last) begin
          cmd.finish_full = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = ST_SCAN_RD;
        end
      end
      ST_ROW_CHK: begin
        cmd.finish_row = 1'b1;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== src/mmt_datapath.sv =====
// mmt_datapath: value store, count store and two-level presence bitmap
// depends on mmt_pkg; driven by mmt_ctrl through dp_cmd_t
module mmt_datapath #(
  parameter int POSITIONS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mmt_pkg::dp_cmd_t     cmd,
  input  logic                 kind,
  input  mmt_pkg::pos_t        position,
  input  mmt_pkg::val_in_t     new_value,
  output mmt_pkg::dp_status_t  status,
  output logic                 done,
  output mmt_pkg::mex_t        mex
);

  localparam int VW   = $clog2(POSITIONS + 2);
  localparam int PAW  = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int CAW  = $clog2(POSITIONS + 1);
  localparam int R1   = (POSITIONS + 1 + mmt_pkg::ROW_W - 1) / mmt_pkg::ROW_W;
  localparam int R1W  = (R1 > 1) ? $clog2(R1) : 1;
  localparam int R2   = (R1 + mmt_pkg::ROW_W - 1) / mmt_pkg::ROW_W;
  localparam int R2W  = (R2 > 1) ? $clog2(R2) : 1;

  typedef logic [VW-1:0]  value_t;
  typedef logic [PAW-1:0] paddr_t;
  typedef logic [CAW-1:0] caddr_t;
  typedef logic [R1W-1:0] raddr_t;
  typedef logic [R2W-1:0] saddr_t;

  // storage
  value_t            stored_mem [POSITIONS];
  mmt_pkg::count_t   count_mem  [POSITIONS + 1];
  mmt_pkg::row_t     row_mem    [R1];
  mmt_pkg::row_t     sum_mem    [R2];

  // latched item and read data
  logic              kind_q;
  mmt_pkg::pos_t     pos_q;
  value_t            val_q;
  value_t            old_q;
  mmt_pkg::count_t   cnt_q;
  mmt_pkg::row_t     row_q;
  mmt_pkg::row_t     sum_q;
  logic              full_q;
  saddr_t            scan_w;
  raddr_t            found_row;
  value_t            clr_addr;
  mmt_pkg::mex_t     mex_q;
  logic              done_q;

  value_t            tgt;
  caddr_t            tgt_cnt;
  raddr_t            tgt_row;
  mmt_pkg::bit_idx_t tgt_bit;
  saddr_t            tgt_sum;
  mmt_pkg::bit_idx_t tgt_sum_bit;
  mmt_pkg::count_t   cnt_new;
  mmt_pkg::row_t     row_new;
  mmt_pkg::row_t     sum_new;
  mmt_pkg::bit_idx_t zb_sum;
  mmt_pkg::bit_idx_t zb_row;
  logic [R2W+mmt_pkg::ROW_LG-1:0] zrow_wide;
  logic [R1W+mmt_pkg::ROW_LG-1:0] idx_wide;
  paddr_t            paddr;
  logic              clr_row_ok;
  logic              clr_sum_ok;

  // position of the lowest clear bit in a word
  function automatic mmt_pkg::bit_idx_t first_zero(input mmt_pkg::row_t w);
    mmt_pkg::bit_idx_t idx;
    idx = '0;
    for (int i = mmt_pkg::ROW_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = mmt_pkg::bit_idx_t'(i);
      end
    end
    return idx;
  endfunction

  // item capture, out-of-range values saturate to the marker
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_q <= kind;
      pos_q  <= position;
      val_q  <= (32'(new_value) > 32'(POSITIONS)) ? value_t'(POSITIONS + 1)
                                                  : value_t'(new_value);
    end
  end

  // target value and its places in the bitmap
  assign tgt         = cmd.sel_new ? val_q : old_q;
  assign tgt_cnt     = caddr_t'(tgt);
  assign tgt_row     = raddr_t'(tgt >> mmt_pkg::ROW_LG);
  assign tgt_bit     = mmt_pkg::bit_idx_t'(tgt);
  assign tgt_sum     = saddr_t'(tgt >> (2 * mmt_pkg::ROW_LG));
  assign tgt_sum_bit = mmt_pkg::bit_idx_t'(tgt >> mmt_pkg::ROW_LG);
  assign paddr       = paddr_t'(pos_q);

  // saturating count adjust and bitmap merge
  always_comb begin
    if (cmd.dec) begin
      cnt_new = (cnt_q == '0) ? '0 : cnt_q - mmt_pkg::count_t'(1);
    end else begin
      cnt_new = (cnt_q == mmt_pkg::CNT_MAX) ? cnt_q : cnt_q + mmt_pkg::count_t'(1);
    end
    row_new          = row_q;
    row_new[tgt_bit] = (cnt_new != '0);
    sum_new              = sum_q;
    sum_new[tgt_sum_bit] = full_q;
  end

  assign clr_row_ok = (32'(clr_addr) < 32'(R1));
  assign clr_sum_ok = (32'(clr_addr) < 32'(R2));

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + value_t'(1);
    end
  end

  // value store
  always_ff @(posedge clk) begin
    if (cmd.stored_wr) begin
      stored_mem[paddr] <= val_q;
    end
    if (cmd.stored_rd) begin
      old_q <= stored_mem[paddr];
    end
  end

  // count store
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      count_mem[caddr_t'(clr_addr)] <= '0;
    end else if (cmd.cnt_wr) begin
      count_mem[tgt_cnt] <= cnt_new;
    end
    if (cmd.cnt_rd) begin
      cnt_q <= count_mem[tgt_cnt];
    end
  end

  // presence rows
  always_ff @(posedge clk) begin
    if (cmd.clr_step && clr_row_ok) begin
      row_mem[raddr_t'(clr_addr)] <= '0;
    end else if (cmd.cnt_wr) begin
      row_mem[tgt_row] <= row_new;
    end
    if (cmd.cnt_rd) begin
      row_q <= row_mem[tgt_row];
    end else if (cmd.row_rd) begin
      row_q <= row_mem[raddr_t'(zrow_wide)];
    end
  end

  // row-full summary words
  always_ff @(posedge clk) begin
    if (cmd.clr_step && clr_sum_ok) begin
      sum_mem[saddr_t'(clr_addr)] <= '0;
    end else if (cmd.sum_wr) begin
      sum_mem[tgt_sum] <= sum_new;
    end
    if (cmd.cnt_wr) begin
      sum_q <= sum_mem[tgt_sum];
    end else if (cmd.scan_rd) begin
      sum_q <= sum_mem[scan_w];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_wr) begin
      full_q <= &row_new;
    end
  end

  // lowest-absent search
  assign zb_sum    = first_zero(sum_q);
  assign zb_row    = first_zero(row_q);
  assign zrow_wide = {scan_w, zb_sum};
  assign idx_wide  = {found_row, zb_row};

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_w <= '0;
    end else if (cmd.latch) begin
      scan_w <= '0;
    end else if (cmd.scan_next) begin
      scan_w <= scan_w + saddr_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_rd) begin
      found_row <= raddr_t'(zrow_wide);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish_full) begin
      mex_q <= mmt_pkg::mex_t'(POSITIONS + 1);
    end else if (cmd.finish_row) begin
      mex_q <= (32'(idx_wide) > 32'(POSITIONS)) ? mmt_pkg::mex_t'(POSITIONS + 1)
                                                : mmt_pkg::mex_t'(idx_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd.finish_full | cmd.finish_row;
    end
  end

  assign done = done_q;
  assign mex  = mex_q;

  // status back to the controller
  assign status.clr_last     = (clr_addr == value_t'(POSITIONS));
  assign status.is_update    = (kind_q == mmt_pkg::KIND_UPDATE);
  assign status.pos_ok       = (32'(pos_q) < 32'(POSITIONS));
  assign status.old_in_range = (32'(old_q) <= 32'(POSITIONS));
  assign status.new_in_range = (32'(val_q) <= 32'(POSITIONS));
  assign status.sum_has_zero = ~&sum_q;
  assign status.zero_beyond  = (32'(zrow_wide) >= 32'(R1));
  assign status.scan_last    = (32'(scan_w) == 32'(R2 - 1));

endmodule

// ===== src/mmt_checker.sv =====
// mmt_checker: port-level assertions for the multiset mex tracker, bound to the top level
// depends on multiset_mex_tracker_defines.svh and mmt_pkg
`include "multiset_mex_tracker_defines.svh"

module mmt_checker #(
  parameter int POSITIONS = 1024
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input mmt_pkg::mex_t     mex
);

  // an accepted item occupies the block on the next cycle
  `MMT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // no item finishes in the cycle right after its accept
  `MMT_ASSERT_NEXT(a_no_early_result, start && !busy, !done)
  // each result pulse lasts a single cycle
  `MMT_ASSERT_NEXT(a_result_pulse, done, !done)
  // a result shows with the block back at idle and in range
  `MMT_ASSERT_SAME(a_result_idle, done, !busy && (32'(mex) <= POSITIONS + 1))

endmodule

bind multiset_mex_tracker mmt_checker #(
  .POSITIONS (POSITIONS)
) u_mmt_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .mex   (mex)
);
